@@ rtl/core/lprd_pkg.sv @@
package lprd_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int BYTE_W       = 8;
	localparam int WORD_W       = 32;
	localparam int KIND_W       = 2;
	localparam int HDR_POS_W    = $clog2(HEADER_BYTES);
	localparam int ASM_W        = (HEADER_BYTES - 1) * BYTE_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD       = 2'd0,
		KIND_EMPTY_WORD    = 2'd1,
		KIND_EMPTY_REQUEST = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_COUNT   = 3'b001,
		PH_LENGTH  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} beat_t;

endpackage

@@ rtl/core/lprd_in_if.sv @@
interface lprd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/core/lprd_out_if.sv @@
interface lprd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] word_index;
	logic        word_end;
	logic        request_end;

	modport source (
		output valid, output kind, output data_byte, output word_index,
		output word_end, output request_end, input ready
	);
	modport sink (
		input valid, input kind, input data_byte, input word_index,
		input word_end, input request_end, output ready
	);
endinterface

@@ rtl/core/length_prefixed_request_deframer_top.sv @@
// Path: a byte accepted sits in the input register; its beat, if it gives one, moves on
// to the result register to be taken there; a result-side stall holds it in place.
// Throughput: one byte per cycle while the result side does not stall; header bytes give
// no beat, but for the last byte of a zero count or length, which gives an empty beat.
// Reset: arst_n clears the parse phase, header position, counters and both
// valid flags at once; the first byte after reset opens a word count.
module length_prefixed_request_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	lprd_in_if.sink    req,
	lprd_out_if.source res
);
	import lprd_pkg::*;

	beat_t beat_s1;
	logic  take;

	lprd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.take    (take),
		.beat_s1 (beat_s1)
	);

	lprd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_s1 (beat_s1),
		.take    (take),
		.res     (res)
	);
endmodule

@@ rtl/core/lprd_in_stage.sv @@
module lprd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	lprd_in_if.sink         req,
	input  logic            take,
	output lprd_pkg::beat_t beat_s1
);
	import lprd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;

	assign req.ready = !valid_s1 || take;
	assign beat_s1   = '{valid: valid_s1, data: data_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			data_s1 <= req.in_byte;
		end
	end
endmodule

@@ rtl/core/lprd_parser.sv @@
module lprd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  lprd_pkg::beat_t beat_s1,
	output logic            take,
	lprd_out_if.source      res
);
	import lprd_pkg::*;

	phase_t               phase_q;
	logic [HDR_POS_W-1:0] hdr_pos_q;
	logic [ASM_W-1:0]     asm_q;
	logic [WORD_W-1:0]    words_q;
	logic [WORD_W-1:0]    remain_q;
	logic [WORD_W-1:0]    cur_word_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [BYTE_W-1:0] data_q;
	logic [WORD_W-1:0] index_q;
	logic              wend_q;
	logic              rend_q;

	logic              hdr_done;
	logic [WORD_W-1:0] value;
	logic              last_word;
	logic              last_byte;
	logic              emit;
	kind_t             kind_d;
	logic [BYTE_W-1:0] data_d;
	logic [WORD_W-1:0] index_d;
	logic              wend_d;
	logic              rend_d;
	logic              finish;

	assign take      = beat_s1.valid && (!out_valid_q || res.ready);
	assign hdr_done  = (hdr_pos_q == HDR_POS_W'(HEADER_BYTES - 1));
	assign value     = {beat_s1.data, asm_q};
	assign last_word = (words_q == WORD_W'(1));
	assign last_byte = (remain_q == WORD_W'(1));

	always_comb begin
		emit    = 1'b0;
		kind_d  = KIND_PAYLOAD;
		data_d  = '0;
		index_d = cur_word_q;
		wend_d  = 1'b0;
		rend_d  = 1'b0;
		finish  = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				emit   = 1'b1;
				data_d = beat_s1.data;
				wend_d = last_byte;
				rend_d = last_byte && last_word;
				finish = last_byte;
			end
			PH_LENGTH: begin
				if (hdr_done && value == '0) begin
					emit   = 1'b1;
					kind_d = KIND_EMPTY_WORD;
					wend_d = 1'b1;
					rend_d = last_word;
					finish = 1'b1;
				end
			end
			default: begin
				if (hdr_done && value == '0) begin
					emit    = 1'b1;
					kind_d  = KIND_EMPTY_REQUEST;
					index_d = '0;
					rend_d  = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COUNT;
			hdr_pos_q   <= '0;
			asm_q       <= '0;
			words_q     <= '0;
			remain_q    <= '0;
			cur_word_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= emit;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (phase_q != PH_PAYLOAD) begin
					hdr_pos_q <= hdr_pos_q + 1'b1;
					for (int i = 0; i < HEADER_BYTES - 1; i++) begin
						if (hdr_pos_q == HDR_POS_W'(i)) begin
							asm_q[i*BYTE_W +: BYTE_W] <= beat_s1.data;
						end
					end
				end
				case (phase_q)
					PH_PAYLOAD: begin
						remain_q <= remain_q - 1'b1;
					end
					PH_LENGTH: begin
						if (hdr_done && value != '0) begin
							remain_q <= value;
							phase_q  <= PH_PAYLOAD;
						end
					end
					default: begin
						if (hdr_done) begin
							cur_word_q <= '0;
							words_q    <= value;
							phase_q    <= (value == '0) ? PH_COUNT : PH_LENGTH;
						end
					end
				endcase
				if (finish) begin
					words_q <= words_q - 1'b1;
					if (last_word) begin
						phase_q    <= PH_COUNT;
						cur_word_q <= '0;
					end else begin
						phase_q    <= PH_LENGTH;
						cur_word_q <= cur_word_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			kind_q  <= kind_d;
			data_q  <= data_d;
			index_q <= index_d;
			wend_q  <= wend_d;
			rend_q  <= rend_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.kind        = kind_q;
	assign res.data_byte   = data_q;
	assign res.word_index  = index_q;
	assign res.word_end    = wend_q;
	assign res.request_end = rend_q;
endmodule
